>>> sv/modular_exponentiation_unit_macros.svh
// assertion macros shared by the rtl
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// same-cycle implication
`define MEU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/meu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package meu_pkg;

   localparam int DATA_WIDTH  = 63;
   localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);
   localparam int REQ_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

   localparam logic [DATA_WIDTH-1:0] RESET_MODULUS = DATA_WIDTH'(64'd1000000007);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_REDUCE  = 6'b000010,
      ST_STEP    = 6'b000100,
      ST_MUL_ACC = 6'b001000,
      ST_MUL_SQR = 6'b010000,
      ST_DONE    = 6'b100000
   } state_type;

   // one shift-and-add step: (2*acc + (bit ? a : 0)) mod m, with acc, a < m
   function automatic logic [DATA_WIDTH-1:0] mod_step(
      input logic [DATA_WIDTH-1:0] acc,
      input logic [DATA_WIDTH-1:0] a,
      input logic [DATA_WIDTH-1:0] m,
      input logic                  bit_in
   );
      logic [DATA_WIDTH+1:0] t;
      logic [DATA_WIDTH+1:0] m1;
      logic [DATA_WIDTH+1:0] m2;
      logic [DATA_WIDTH+1:0] r;
      t  = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, a} : '0);
      m1 = {2'b00, m};
      m2 = {1'b0, m, 1'b0};
      if (t >= m2) begin
         r = t - m2;
      end else if (t >= m1) begin
         r = t - m1;
      end else begin
         r = t;
      end
      return r[DATA_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// every modular product, and the reduction of the base after accept, runs on the shared
//   shift-and-add unit; an item costs that reduction plus one product for each squaring
//   and one for each set exponent bit
// throughput: one item at a time, req_tready is high only while the sequencer is idle
// reset: synchronous, active high; modulus returns to 1000000007, no result pending
`include "modular_exponentiation_unit_macros.svh"
module modular_exponentiation_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // modulus write channel
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [meu_pkg::DATA_WIDTH-1:0]     csr_data,
   // request items
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [meu_pkg::REQ_TDATA_W-1:0]    req_tdata,   // base, exponent, zero pad
   input  wire logic [0:0]                         req_tuser,   // func
   // result items
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [meu_pkg::RSP_TDATA_W-1:0]    rsp_tdata    // result, zero pad
);

   localparam int W = meu_pkg::DATA_WIDTH;

   // configuration
   logic [W-1:0] modulus_ff, modulus_in;

   // sequencer
   meu_pkg::state_type state_ff, state_in;

   // operands of the current item
   logic [W-1:0] mod_ff,  mod_in;     // modulus captured at accept
   logic [W-1:0] exp_ff,  exp_in;     // remaining exponent bits
   logic [W-1:0] base_ff, base_in;    // running square of base
   logic [W-1:0] res_ff,  res_in;     // running result

   // shared modular multiplier: acc = a * b mod m, msb of b first
   logic [W-1:0]                  mul_a_ff,   mul_a_in;
   logic [W-1:0]                  mul_b_ff,   mul_b_in;
   logic [W-1:0]                  mul_acc_ff, mul_acc_in;
   logic [meu_pkg::CNT_WIDTH-1:0] cnt_ff,     cnt_in;
   logic [W-1:0]                  mul_step;
   logic                          mul_last;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff,  rsp_data_in;

   logic         req_fire;
   logic         rsp_free;
   logic [W-1:0] req_base;
   logic [W-1:0] req_exp;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == meu_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_base   = req_tdata[W-1:0];
   assign req_exp    = req_tdata[2*W-1:W];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = meu_pkg::RSP_TDATA_W'(rsp_data_ff);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // one shift-and-add step per cycle
   assign mul_step = meu_pkg::mod_step(mul_acc_ff, mul_a_ff, mod_ff, mul_b_ff[W-1]);
   assign mul_last = (cnt_ff == meu_pkg::CNT_WIDTH'(W - 1));

   always_comb begin
      modulus_in   = modulus_ff;
      state_in     = state_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_acc_in   = mul_acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         modulus_in = csr_data;
      end

      // multiplier advances in every multiply state
      mul_acc_in = mul_step;
      mul_b_in   = {mul_b_ff[W-2:0], 1'b0};
      cnt_in     = cnt_ff + 1'b1;

      unique case (state_ff)
         meu_pkg::ST_IDLE: begin
            if (req_fire) begin
               mod_in = modulus_ff;
               res_in = W'(1);
               // base mod m via horner over the bits of base with a = 1
               mul_a_in   = W'(1);
               mul_b_in   = req_base;
               mul_acc_in = '0;
               cnt_in     = '0;
               if (modulus_ff < W'(2)) begin
                  // no residue but zero
                  res_in   = '0;
                  state_in = meu_pkg::ST_DONE;
               end else begin
                  exp_in   = req_tuser[0] ? (modulus_ff - W'(2)) : req_exp;
                  state_in = meu_pkg::ST_REDUCE;
               end
            end
         end
         meu_pkg::ST_REDUCE: begin
            if (mul_last) begin
               base_in  = mul_step;
               state_in = meu_pkg::ST_STEP;
            end
         end
         meu_pkg::ST_STEP: begin
            mul_acc_in = '0;
            cnt_in     = '0;
            mul_b_in   = base_ff;
            if (exp_ff == '0) begin
               state_in = meu_pkg::ST_DONE;
            end else if (exp_ff[0]) begin
               mul_a_in = res_ff;
               state_in = meu_pkg::ST_MUL_ACC;
            end else begin
               mul_a_in = base_ff;
               state_in = meu_pkg::ST_MUL_SQR;
            end
         end
         meu_pkg::ST_MUL_ACC: begin
            if (mul_last) begin
               res_in    = mul_step;
               exp_in[0] = 1'b0;
               state_in  = meu_pkg::ST_STEP;
            end
         end
         meu_pkg::ST_MUL_SQR: begin
            if (mul_last) begin
               base_in  = mul_step;
               exp_in   = exp_ff >> 1;
               state_in = meu_pkg::ST_STEP;
            end
         end
         meu_pkg::ST_DONE: begin
            // wait for the output register to drain
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = meu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = meu_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= meu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= meu_pkg::RESET_MODULUS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mod_ff      <= mod_in;
      exp_ff      <= exp_in;
      base_ff     <= base_in;
      res_ff      <= res_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_acc_ff  <= mul_acc_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `MEU_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `MEU_ASSERT_NOW(a_mul_acc_reduced, clock, reset,
      (state_ff == meu_pkg::ST_MUL_ACC) || (state_ff == meu_pkg::ST_MUL_SQR),
      mul_acc_ff < mod_ff)
   `MEU_ASSERT_NOW(a_result_reduced, clock, reset,
      (state_ff == meu_pkg::ST_DONE) && (mod_ff >= W'(2)), res_ff < mod_ff)
   `MEU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)

endmodule
`default_nettype wire

>>> dv/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps
module modular_exponentiation_unit_tb;

   localparam int DW          = meu_pkg::DATA_WIDTH;
   localparam int REQ_W       = meu_pkg::REQ_TDATA_W;
   localparam int RSP_W       = meu_pkg::RSP_TDATA_W;
   localparam int IDLE_LIMIT  = 60000;  // covers the worst item plus the long stall
   localparam int STALL_LEN   = 2500;
   localparam int STALL_AFTER = 100;    // results seen before the long receiver stall
   localparam int MAX_SHOWN   = 10;

   typedef logic [DW-1:0]   word_type;
   typedef logic [2*DW-1:0] wide_type;

   localparam logic FUNC_POWER   = 1'b0;
   localparam logic FUNC_INVERSE = 1'b1;

   localparam word_type WORD_MAX = {DW{1'b1}};
   localparam word_type ALT_HI   = DW'(64'hAAAA_AAAA_AAAA_AAAA);
   localparam word_type ALT_LO   = DW'(64'h5555_5555_5555_5555);

   typedef struct packed {
      logic     func;
      word_type base;
      word_type exponent;
   } request_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   word_type          csr_data   = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;  // base, exponent, zero pad
   logic [0:0]        req_tuser  = '0;  // func
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;        // result, zero pad

   request_type pending_requests[$];
   word_type    expected_residues[$];
   word_type    active_modulus = meu_pkg::RESET_MODULUS;
   bit          no_gaps        = 1'b0;
   int          mismatches     = 0;
   int          results_seen   = 0;
   int          stall_left     = 0;
   bit          stall_done     = 1'b0;
   int          quiet_cycles   = 0;

   modular_exponentiation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // exact double-width product reduced by the modulus
   function automatic word_type product_residue(input word_type a, input word_type b,
                                                input word_type m);
      wide_type prod;
      prod = wide_type'(a) * wide_type'(b);
      return word_type'(prod % wide_type'(m));
   endfunction

   // power or fermat inverse, right-to-left square and multiply
   function automatic word_type power_residue(input logic func, input word_type base,
                                              input word_type exponent, input word_type m);
      word_type acc;
      word_type sq;
      word_type e;
      if (m < 2) return '0;
      e   = (func == FUNC_INVERSE) ? m - 2 : exponent;
      acc = 1;
      sq  = base % m;
      while (e != 0) begin
         if (e[0]) acc = product_residue(acc, sq, m);
         sq = product_residue(sq, sq, m);
         e  = e >> 1;
      end
      return acc;
   endfunction

   function automatic word_type rand_word();
      return DW'({$urandom(), $urandom()});
   endfunction

   // random value of the given bit length or shorter
   function automatic word_type rand_bits(input int w);
      if (w <= 0) return '0;
      return rand_word() >> (DW - w);
   endfunction

   task automatic push_request(input logic func, input word_type base,
                               input word_type exponent);
      request_type r;
      r.func     = func;
      r.base     = base;
      r.exponent = exponent;
      pending_requests.push_back(r);
   endtask

   task automatic push_random_request(input int inverse_pct);
      word_type m;
      word_type b;
      word_type e;
      int       pick;
      m    = active_modulus;
      pick = $urandom_range(9);
      case (pick)
         0: begin
            b = word_type'($urandom_range(3));
         end
         1: begin
            b = m * word_type'($urandom_range(1, 3));  // multiple of the modulus, may wrap
         end
         2: begin
            b = m - 1;
         end
         3, 4, 5: begin
            b = (m < 2) ? rand_word() : rand_word() % m;
         end
         default: begin
            b = rand_word();
         end
      endcase
      pick = $urandom_range(99);
      if (pick < 4) begin
         e = rand_word();
      end else if (pick < 8) begin
         e = (pick < 5) ? '0 : (pick < 6) ? word_type'(1) : WORD_MAX;
      end else if (pick < 30) begin
         e = rand_bits($urandom_range(9, 20));
      end else begin
         e = rand_bits($urandom_range(0, 8));
      end
      push_request(($urandom_range(99) < inverse_pct) ? FUNC_INVERSE : FUNC_POWER, b, e);
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
   endtask

   // nothing queued, nothing in flight, no result outstanding
   // sampled at the falling edge so the driver's updates have settled
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_residues.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input word_type modulus_value, input bit write_it,
                            input int random_count, input int inverse_pct, input bit calm);
      word_type m;
      wait_until_drained();
      if (write_it) begin
         csr_data  <= modulus_value;
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid      <= 1'b0;
         active_modulus  = modulus_value;
      end
      no_gaps <= calm;
      m = active_modulus;
      // corners around the modulus for every setting
      push_request(FUNC_POWER, m, 3);
      push_request(FUNC_INVERSE, m, rand_word());
      push_request(FUNC_INVERSE, m - 1, '0);
      push_request(FUNC_POWER, m - 1, 1);
      push_request(FUNC_POWER, WORD_MAX, '0);
      push_request(FUNC_INVERSE, WORD_MAX, rand_word());
      push_request(FUNC_POWER, (m < 2) ? rand_word() : rand_word() % m, 2);
      repeat (random_count) push_random_request(inverse_pct);
   endtask

   // driver: offers queued items, predicts each one as it is accepted
   always @(posedge clock) begin
      bit          give;
      request_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_residues.push_back(power_residue(req_tuser[0], req_tdata[DW-1:0],
                                                      req_tdata[2*DW-1:DW], active_modulus));
         end
         if (!req_tvalid || req_tready) begin
            give = pending_requests.size() != 0 && (no_gaps || $urandom_range(99) >= 35);
            if (give) begin
               next_item = pending_requests.pop_front();
               req_tdata <= REQ_W'({next_item.exponent, next_item.base});
               req_tuser <= next_item.func;
            end
            req_tvalid <= give;
         end
      end
   end

   // monitor: checks each result item against the oldest prediction
   always @(posedge clock) begin
      word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_residues.size() == 0) begin
               report_mismatch($sformatf("unexpected result item %0d", rsp_tdata[DW-1:0]));
            end else begin
               want = expected_residues.pop_front();
               if (rsp_tdata[DW-1:0] !== want)
                  report_mismatch($sformatf("result expected %0d got %0d (modulus %0d)",
                                            want, rsp_tdata[DW-1:0], active_modulus));
            end
         end
         // one long hold-off so the block backs up onto its input
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!stall_done && results_seen >= STALL_AFTER) begin
            stall_done  = 1'b1;
            stall_left  = STALL_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_gaps || $urandom_range(99) >= 35;
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      word_type m;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed items at the reset modulus
      m = meu_pkg::RESET_MODULUS;
      push_request(FUNC_POWER, '0, '0);
      push_request(FUNC_POWER, WORD_MAX, '0);
      push_request(FUNC_POWER, '0, 1);
      push_request(FUNC_POWER, WORD_MAX, WORD_MAX);
      push_request(FUNC_POWER, 1, WORD_MAX);
      push_request(FUNC_POWER, m - 1, 2);
      push_request(FUNC_POWER, m, 3);
      push_request(FUNC_POWER, m + 1, 5);
      push_request(FUNC_POWER, 2, 62);
      push_request(FUNC_POWER, rand_word(), 1);
      push_request(FUNC_POWER, ALT_HI, ALT_LO);
      push_request(FUNC_POWER, ALT_LO, ALT_HI);
      push_request(FUNC_INVERSE, '0, '0);
      push_request(FUNC_INVERSE, 1, '0);
      push_request(FUNC_INVERSE, 2, ALT_HI);
      push_request(FUNC_INVERSE, m, '0);
      push_request(FUNC_INVERSE, WORD_MAX, WORD_MAX);
      push_request(FUNC_INVERSE, m - 1, WORD_MAX);
      push_request(FUNC_INVERSE, 12345, rand_word());

      run_phase(meu_pkg::RESET_MODULUS, 1'b0, 150, 15, 1'b0);
      run_phase(2, 1'b1, 60, 40, 1'b0);
      run_phase(3, 1'b1, 60, 40, 1'b0);
      run_phase(DW'(64'h1FFF_FFFF_FFFF_FFFF), 1'b1, 140, 10, 1'b0);  // mersenne prime
      run_phase(WORD_MAX, 1'b1, 90, 8, 1'b0);  // composite, inverse is a plain power
      run_phase(998244353, 1'b1, 120, 15, 1'b1);
      run_phase(1, 1'b1, 6, 50, 1'b0);         // no residue but zero
      run_phase(0, 1'b1, 6, 50, 1'b0);
      m = rand_word();
      run_phase((m < 2) ? word_type'(2) : m, 1'b1, 60, 5, 1'b0);
      m = rand_bits(20);
      run_phase((m < 2) ? word_type'(2) : m, 1'b1, 80, 25, 1'b0);
      m = rand_bits(8);
      run_phase((m < 2) ? word_type'(2) : m, 1'b1, 80, 30, 1'b0);
      run_phase(DW'(64'd4294967291), 1'b1, 100, 15, 1'b0);
      run_phase(65537, 1'b1, 100, 20, 1'b0);
      run_phase(meu_pkg::RESET_MODULUS, 1'b1, 40, 15, 1'b0);

      wait_until_drained();
      repeat (500) @(posedge clock);
      if (expected_residues.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_residues.size()));
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
